/* design/deth_pkg.sv */
// Shared types and constants for the directional edge threshold block.
// No dependencies; imported by the window module and the top level.
`default_nettype none

package deth_pkg;

   localparam int SIZE_W     = 12;
   localparam int ROW_W      = 12;
   localparam int COORD_W    = 11;
   localparam int THRESH_W   = 8;
   localparam int MAX_HEIGHT = 2048;
   localparam int MIN_SIZE   = 3;

   localparam logic [1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_WIDTH     = 2'd1;
   localparam logic [1:0] CSR_HEIGHT    = 2'd2;

   localparam logic MODE_PIXEL = 1'b0;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd32;
   localparam logic [SIZE_W-1:0]   WIDTH_RESET  = 12'd640;
   localparam logic [ROW_W-1:0]    HEIGHT_RESET = 12'd480;

   typedef struct packed {
      logic shift;
      logic edge_en;
   } deth_step_type;

endpackage

`default_nettype wire

/* design/deth_line_mem.sv */
// Two-row line buffer memory with one write and one registered read port.
// Standalone; used by the top level to hold the two rows above the input row.
`default_nettype none

module deth_line_mem #(
   parameter int DEPTH  = 2048,
   parameter int DATA_W = 16,
   parameter int ADDR_W = 11
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/deth_window.sv */
// 3x3 window registers and the four-direction difference test.
// Depends on deth_pkg for the step control struct.
`default_nettype none

module deth_window
   import deth_pkg::*;
#(
   parameter int PIXEL_BITS = 8
) (
   input  wire logic                  clock,
   input  wire deth_step_type         step,
   input  wire logic [PIXEL_BITS-1:0] pixel,
   input  wire logic [PIXEL_BITS-1:0] up_pixel,
   input  wire logic [PIXEL_BITS-1:0] mid_pixel,
   input  wire logic [THRESH_W-1:0]   threshold,
   output logic                       edge_flag
);

   logic [PIXEL_BITS-1:0] top1_ff, top2_ff, mid1_ff, mid2_ff, bot1_ff, bot2_ff;
   logic [PIXEL_BITS-1:0] diag_a, vert, diag_b, horz;
   logic [PIXEL_BITS-1:0] thr;

   always_ff @(posedge clock) begin
      if (step.shift) begin
         top1_ff <= top2_ff;
         top2_ff <= up_pixel;
         mid1_ff <= mid2_ff;
         mid2_ff <= mid_pixel;
         bot1_ff <= bot2_ff;
         bot2_ff <= pixel;
      end
   end

   // Differences are taken on the window as it stands after this shift.
   always_comb begin
      diag_a = (top1_ff > pixel)    ? top1_ff - pixel    : pixel - top1_ff;
      vert   = (top2_ff > bot2_ff)  ? top2_ff - bot2_ff  : bot2_ff - top2_ff;
      diag_b = (up_pixel > bot1_ff) ? up_pixel - bot1_ff : bot1_ff - up_pixel;
      horz   = (mid1_ff > mid_pixel) ? mid1_ff - mid_pixel : mid_pixel - mid1_ff;
      thr    = PIXEL_BITS'(threshold);
      edge_flag = step.edge_en &&
                  ((diag_a > thr) || (vert > thr) || (diag_b > thr) || (horz > thr));
   end

endmodule

`default_nettype wire

/* design/directional_edge_threshold_top.sv */
// Top level of the directional edge threshold block: counters, pipeline and output register.
// Depends on deth_pkg, deth_line_mem and deth_window.
//
// The req channel carries raster pixels (tuser = 0) or flush items (tuser = 1).
// The rsp channel returns one edge result per pixel position, in raster order,
// with tlast on the final result of a frame. Each result trails its input by one
// row plus one pixel; flush items after the last pixel push out the remaining
// results. Border pixels always give no edge.
// The csr channel writes the threshold, width or height; a size write restarts
// the frame counters. It is always ready and should be used while idle.
// A result enters the rsp register when the window stage holding its item moves on: the
// accepting edge loads that stage and starts the line memory read, and the edge that
// advances the stage applies the window update and difference test. One item is accepted
// every cycle unless rsp stalls; the line memory read/write port pair sets that rate.
// When rsp_tready is low the result stays in the output register, one more item
// waits in the window stage, and req_tready falls.
// Reset clears counters and valid flags; the line memory needs no clearing pass
// because unwritten entries never reach an interior result.
`default_nettype none

module directional_edge_threshold_top
   import deth_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int PIXEL_BITS = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // gray_pixel
   input  wire logic [((PIXEL_BITS+7)/8)*8-1:0]     req_tdata,
   // mode
   input  wire logic [0:0]                          req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // edge_flag, pixel_column, pixel_row, zero pad
   output logic [23:0]                              rsp_tdata,
   output logic                                     rsp_tlast,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [1:0]                          csr_addr,
   input  wire logic [SIZE_W-1:0]                   csr_wdata
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int EW_W  = $clog2(MAX_WIDTH + 1);
   localparam logic [EW_W-1:0] EFF_W_RESET =
      (640 > MAX_WIDTH) ? EW_W'(MAX_WIDTH) : EW_W'(640);

   logic [THRESH_W-1:0] threshold_ff;
   logic [EW_W-1:0]     width_eff_ff, width_eff_in;
   logic [ROW_W-1:0]    height_eff_ff, height_eff_in;

   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;

   logic                  s1_valid_ff, s1_emit_ff, s1_last_ff;
   deth_step_type         s1_ctrl_ff;
   logic [PIXEL_BITS-1:0] s1_pix_ff;
   logic [COL_W-1:0]      s1_addr_ff;
   logic [COORD_W-1:0]    s1_col_ff, s1_row_ff;

   logic       rsp_valid_ff;
   logic [23:0] rsp_data_ff;
   logic       rsp_last_ff;

   logic req_fire, s1_go, csr_fire, restart;
   logic is_pix, pix_ok, emit_pix, flush_ok, s0_emit, s0_last, s0_edge_en;
   logic in_col_wrap, out_col_wrap;
   logic [PIXEL_BITS-1:0] pixel_in;

   logic [2*PIXEL_BITS-1:0] mem_rd_data;
   logic                    mem_wr_en;
   deth_step_type           step;
   logic                    edge_flag;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign pixel_in  = req_tdata[PIXEL_BITS-1:0];

   always_comb begin
      if (32'(csr_wdata) < MIN_SIZE) begin
         width_eff_in = EW_W'(MIN_SIZE);
      end else if (32'(csr_wdata) > MAX_WIDTH) begin
         width_eff_in = EW_W'(MAX_WIDTH);
      end else begin
         width_eff_in = EW_W'(csr_wdata);
      end
      if (32'(csr_wdata) < MIN_SIZE) begin
         height_eff_in = ROW_W'(MIN_SIZE);
      end else if (32'(csr_wdata) > MAX_HEIGHT) begin
         height_eff_in = ROW_W'(MAX_HEIGHT);
      end else begin
         height_eff_in = ROW_W'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= THRESH_RESET;
         width_eff_ff  <= EFF_W_RESET;
         height_eff_ff <= HEIGHT_RESET;
      end else if (csr_fire) begin
         case (csr_addr)
            CSR_THRESHOLD: threshold_ff <= csr_wdata[THRESH_W-1:0];
            CSR_WIDTH:     width_eff_ff <= width_eff_in;
            CSR_HEIGHT:    height_eff_ff <= height_eff_in;
            default: ;
         endcase
      end
   end

   assign restart = csr_fire && ((csr_addr == CSR_WIDTH) || (csr_addr == CSR_HEIGHT));

   // Pipeline handshake.
   assign s1_go      = s1_valid_ff && (!s1_emit_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_fire   = req_tvalid && req_tready;

   // Decode of the incoming item against the frame counters.
   always_comb begin
      is_pix       = (req_tuser[0] == MODE_PIXEL);
      pix_ok       = is_pix && (in_row_ff < height_eff_ff);
      emit_pix     = pix_ok && ((in_col_ff == '0) ? (in_row_ff >= ROW_W'(2))
                                                  : (in_row_ff >= ROW_W'(1)));
      s0_edge_en   = (in_col_ff >= COL_W'(2)) && (in_row_ff >= ROW_W'(2));
      flush_ok     = !is_pix && (in_row_ff >= height_eff_ff) && (out_row_ff < height_eff_ff);
      s0_emit      = emit_pix || flush_ok;
      in_col_wrap  = ((EW_W'(in_col_ff) + EW_W'(1)) == width_eff_ff);
      out_col_wrap = ((EW_W'(out_col_ff) + EW_W'(1)) == width_eff_ff);
      s0_last      = flush_ok && out_col_wrap && (out_row_ff == height_eff_ff - ROW_W'(1));

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (req_fire && pix_ok) begin
         if (in_col_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + ROW_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
      end
      if (req_fire && s0_emit) begin
         if (out_col_wrap) begin
            out_col_in = '0;
            out_row_in = out_row_ff + ROW_W'(1);
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
      end
      if ((req_fire && s0_last) || restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // Window stage register; the memory read is in flight alongside it.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= pix_ok || s0_emit;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ctrl_ff.shift   <= pix_ok;
         s1_ctrl_ff.edge_en <= s0_edge_en;
         s1_emit_ff         <= s0_emit;
         s1_last_ff         <= s0_last;
         s1_pix_ff          <= pixel_in;
         s1_addr_ff         <= in_col_ff;
         s1_col_ff          <= COORD_W'(out_col_ff);
         s1_row_ff          <= COORD_W'(out_row_ff);
      end
   end

   assign mem_wr_en = s1_go && s1_ctrl_ff.shift;

   deth_line_mem #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (2 * PIXEL_BITS),
      .ADDR_W (COL_W)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (in_col_ff),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data ({s1_pix_ff, mem_rd_data[2*PIXEL_BITS-1:PIXEL_BITS]})
   );

   assign step.shift   = mem_wr_en;
   assign step.edge_en = s1_ctrl_ff.edge_en;

   deth_window #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_window (
      .clock     (clock),
      .step      (step),
      .pixel     (s1_pix_ff),
      .up_pixel  (mem_rd_data[PIXEL_BITS-1:0]),
      .mid_pixel (mem_rd_data[2*PIXEL_BITS-1:PIXEL_BITS]),
      .threshold (threshold_ff),
      .edge_flag (edge_flag)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_emit_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_emit_ff) begin
         rsp_data_ff <= {1'b0, s1_row_ff, s1_col_ff, edge_flag};
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      EW_W'(in_col_ff) < width_eff_ff)
      else $error("input column beyond image width");

   a_out_in_range: assert property (@(posedge clock) disable iff (reset)
      (out_row_ff < height_eff_ff) && (EW_W'(out_col_ff) < width_eff_ff))
      else $error("result position beyond frame");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (req_fire && s0_last) |=> (in_col_ff == '0) && (in_row_ff == '0) &&
                                (out_col_ff == '0) && (out_row_ff == '0))
      else $error("counters not cleared after frame end");

   a_stall_holds_read: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> $stable(mem_rd_data))
      else $error("line memory data lost during stall");

endmodule

`default_nettype wire

/* tb/edge_result_checker.sv */
// Checker for the directional edge threshold block: watches the req, rsp and csr channels,
// predicts each edge result from the accepted pixels and compares it field by field.
// Depends on deth_pkg for the register indexes, the pixel mode code and the reset values.
`timescale 1ns / 1ps

module edge_result_checker
   import deth_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   input  wire logic                req_tready,
   input  wire logic [7:0]          req_tdata,
   input  wire logic [0:0]          req_tuser,
   input  wire logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   input  wire logic [23:0]         rsp_tdata,
   input  wire logic                rsp_tlast,
   input  wire logic                csr_valid,
   input  wire logic                csr_ready,
   input  wire logic [1:0]          csr_addr,
   input  wire logic [SIZE_W-1:0]   csr_wdata,
   output int                       mismatch_count,
   output int                       pending_count
);

   localparam int LINE_DEPTH = 2048;

   typedef struct packed {
      logic               is_edge;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row_index;
      logic               frame_end;
   } edge_result_type;

   edge_result_type     expected_results[$];
   logic [7:0]          upper_line[LINE_DEPTH];
   logic [7:0]          middle_line[LINE_DEPTH];
   logic [7:0]          window[9];
   logic [THRESH_W-1:0] threshold;
   logic [SIZE_W-1:0]   width_reg;
   logic [SIZE_W-1:0]   height_reg;
   logic [11:0]         next_col;
   logic [ROW_W-1:0]    next_row;
   logic [22:0]         sent_count;
   int                  fail_total = 0;

   assign mismatch_count = fail_total;

   task automatic report_mismatch(input string what);
      $display("%0t: %s", $time, what);
      fail_total++;
   endtask

   task automatic predict_edge_result(input logic mode, input logic [7:0] pixel);
      int w, h, total, c, r, col, rw, top_px, mid_px, best, diff;
      logic emit, found_edge, last;
      w = (width_reg < 3) ? 3 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : int'(width_reg));
      h = (height_reg < 3) ? 3 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg));
      found_edge = 1'b0;
      last = 1'b0;
      if (mode == MODE_PIXEL) begin
         c = next_col;
         r = next_row;
         if (r >= h || c >= w) return;
         top_px = upper_line[c];
         mid_px = middle_line[c];
         upper_line[c] = 8'(mid_px);
         middle_line[c] = pixel;
         window[0] = window[1];
         window[1] = window[2];
         window[2] = 8'(top_px);
         window[3] = window[4];
         window[4] = window[5];
         window[5] = 8'(mid_px);
         window[6] = window[7];
         window[7] = window[8];
         window[8] = pixel;
         if (c == 0) begin
            emit = (r >= 2);
            col = w - 1;
            rw = r - 2;
         end else begin
            emit = (r >= 1);
            col = c - 1;
            rw = r - 1;
            if (c >= 2 && r >= 2) begin
               // Opposite pixels across the center: diagonals, vertical, horizontal.
               best = 0;
               for (int k = 0; k < 4; k++) begin
                  diff = int'(window[k]) - int'(window[8-k]);
                  if (diff < 0) diff = -diff;
                  if (diff > best) best = diff;
               end
               found_edge = (best > threshold);
            end
         end
         c++;
         if (c == w) begin
            c = 0;
            r++;
         end
         next_col = 12'(c);
         next_row = ROW_W'(r);
         if (!emit) return;
         sent_count++;
      end else begin
         total = w * h;
         if (next_row < h || sent_count >= total) return;
         col = sent_count % w;
         rw = sent_count / w;
         sent_count++;
         if (sent_count == total) begin
            last = 1'b1;
            next_col = '0;
            next_row = '0;
            sent_count = '0;
         end
      end
      expected_results.insert(expected_results.size(),
                              '{found_edge, col[COORD_W-1:0], rw[COORD_W-1:0], last});
   endtask

   // Transfers happen at the rising edge; all channel signals are stable from the
   // falling edge before it, so they are sampled there.
   always @(negedge clock) begin
      edge_result_type want;
      if (reset) begin
         threshold = THRESH_RESET;
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         foreach (upper_line[i]) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
         end
         foreach (window[i]) window[i] = '0;
         next_col = '0;
         next_row = '0;
         sent_count = '0;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_addr)
               CSR_THRESHOLD: threshold = csr_wdata[THRESH_W-1:0];
               CSR_WIDTH, CSR_HEIGHT: begin
                  if (csr_addr == CSR_WIDTH) width_reg = csr_wdata;
                  else height_reg = csr_wdata;
                  next_col = '0;
                  next_row = '0;
                  sent_count = '0;
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_edge_result(req_tuser[0], req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result, data %h last %b",
                                         rsp_tdata, rsp_tlast));
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[0] !== want.is_edge)
                  report_mismatch($sformatf("edge flag at row %0d col %0d: got %b, want %b",
                                            want.row_index, want.column, rsp_tdata[0],
                                            want.is_edge));
               if (rsp_tdata[11:1] !== want.column)
                  report_mismatch($sformatf("column: got %0d, want %0d",
                                            rsp_tdata[11:1], want.column));
               if (rsp_tdata[22:12] !== want.row_index)
                  report_mismatch($sformatf("row: got %0d, want %0d",
                                            rsp_tdata[22:12], want.row_index));
               if (rsp_tdata[23] !== 1'b0)
                  report_mismatch("padding bit of rsp_tdata is not zero");
               if (rsp_tlast !== want.frame_end)
                  report_mismatch($sformatf("frame end at row %0d col %0d: got %b, want %b",
                                            want.row_index, want.column, rsp_tlast,
                                            want.frame_end));
            end
         end
      end
      pending_count = expected_results.size();
   end

endmodule

/* tb/tb.sv */
// Top of the directional edge threshold testbench: clock, reset, stimulus and verdict.
// Depends on deth_pkg, directional_edge_threshold_top and edge_result_checker.
`timescale 1ns / 1ps

module tb;
   import deth_pkg::*;

   localparam logic [1:0] CSR_SPARE = 2'd3;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata = '0;
   logic [0:0]        req_tuser = MODE_PIXEL;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [23:0]       rsp_tdata;
   logic              rsp_tlast;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_addr = CSR_THRESHOLD;
   logic [SIZE_W-1:0] csr_wdata = '0;
   int                mismatch_count;
   int                pending_count;

   int burst_left = 0;
   int cur_w = 640;
   int cur_h = 480;
   int items_done = 0;
   bit frame_cut = 1'b1;
   int stall_kind = 0;
   int stall_left = 0;

   always #2 clock = ~clock;

   directional_edge_threshold_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   edge_result_checker results_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // The receiver switches between always ready, random stalls and long stalls.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_kind = $urandom_range(0, 3);
         stall_left = $urandom_range(16, 200);
      end
      stall_left--;
      case (stall_kind)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (stall_left % 6 == 0);
         default: rsp_tready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   task automatic send_item(input logic mode, input logic [7:0] pixel);
      int gap;
      bit taken;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= pixel;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [SIZE_W-1:0] value);
      bit taken;
      csr_valid <= 1'b1;
      csr_addr <= index;
      csr_wdata <= value;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic close_writes();
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits for every expected result, then lets ignored items drain from the pipeline.
   task automatic wait_idle();
      bit busy;
      req_tvalid <= 1'b0;
      burst_left = 0;
      do begin
         @(negedge clock);
         busy = (pending_count != 0);
         @(posedge clock);
      end while (busy);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_frame(input logic [SIZE_W-1:0] thr_v, input logic [SIZE_W-1:0] w_v,
                            input logic [SIZE_W-1:0] h_v);
      wait_idle();
      write_reg(CSR_THRESHOLD, thr_v);
      write_reg(CSR_WIDTH, w_v);
      write_reg(CSR_HEIGHT, h_v);
      close_writes();
      cur_w = (w_v < 3) ? 3 : ((w_v > 2048) ? 2048 : int'(w_v));
      cur_h = (h_v < 3) ? 3 : ((h_v > MAX_HEIGHT) ? MAX_HEIGHT : int'(h_v));
   endtask

   // Sends one frame and its flush tail. With noise, early flushes and stray pixels
   // are mixed in and some frames are cut short.
   task automatic run_frame(input int style, input bit noisy);
      int n_pix, stop_at;
      logic [7:0] px;
      n_pix = cur_w * cur_h;
      frame_cut = noisy && ($urandom_range(0, 9) == 0);
      stop_at = frame_cut ? $urandom_range(1, n_pix - 1) : n_pix;
      for (int i = 0; i < stop_at; i++) begin
         if (noisy && $urandom_range(0, 23) == 0)
            send_item(~MODE_PIXEL, 8'($urandom_range(0, 255)));
         case (style)
            0: px = 8'($urandom_range(0, 255));
            1: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: px = 8'd100 + 8'($urandom_range(0, 48));
         endcase
         send_item(MODE_PIXEL, px);
         items_done++;
      end
      if (frame_cut) return;
      if (noisy && $urandom_range(0, 3) == 0)
         send_item(MODE_PIXEL, 8'($urandom_range(0, 255)));
      for (int i = 0; i <= cur_w; i++) begin
         send_item(~MODE_PIXEL, 8'($urandom_range(0, 255)));
         items_done++;
      end
      if (noisy && $urandom_range(0, 3) == 0)
         send_item(~MODE_PIXEL, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      int waited;
      bit busy;
      logic [SIZE_W-1:0] thr_v, w_v, h_v;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Smallest frame with a strong vertical step, lowest threshold, and the
      // ignored cases: early flush, pixel after the frame, flush after the tail.
      set_frame(12'd0, 12'd3, 12'd3);
      write_reg(CSR_SPARE, 12'hFFF);
      close_writes();
      send_item(~MODE_PIXEL, 8'hFF);
      for (int i = 0; i < 9; i++) send_item(MODE_PIXEL, (i >= 6) ? 8'hFF : 8'h00);
      send_item(MODE_PIXEL, 8'hFF);
      for (int i = 0; i < 4; i++) send_item(~MODE_PIXEL, 8'h00);
      send_item(~MODE_PIXEL, 8'h00);
      set_frame(12'd255, 12'd3, 12'd3);
      run_frame(1, 1'b0);

      // Size values below the clamps and a threshold wider than eight bits.
      set_frame(SIZE_W'($urandom_range(0, 4095)), 12'd2, 12'd1);
      run_frame(0, 1'b0);
      set_frame(12'hF30, 12'd4, 12'd0);
      run_frame(0, 1'b0);

      items_done = 0;
      frame_cut = 1'b1;
      while (items_done < 600) begin
         if (frame_cut || $urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 3))
               0: thr_v = 12'd0;
               1: thr_v = 12'd255;
               2: thr_v = SIZE_W'($urandom_range(0, 4095));
               default: thr_v = SIZE_W'($urandom_range(10, 80));
            endcase
            w_v = SIZE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                      : $urandom_range(3, 10));
            h_v = SIZE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                      : $urandom_range(3, 6));
            set_frame(thr_v, w_v, h_v);
            if ($urandom_range(0, 7) == 0) begin
               write_reg(CSR_SPARE, SIZE_W'($urandom_range(0, 4095)));
               close_writes();
            end
         end
         run_frame($urandom_range(0, 2), 1'b1);
      end

      req_tvalid <= 1'b0;
      waited = 0;
      do begin
         @(negedge clock);
         busy = (pending_count != 0);
         @(posedge clock);
         waited++;
      end while (busy && waited < 100000);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("directional_edge_threshold_top: match");
      end else begin
         $display("directional_edge_threshold_top: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("directional_edge_threshold_top: mismatch");
      $finish;
   end

endmodule
